// ===== rtl/sha512_256_hash_core_defines.svh =====
// Assertion macros shared by the hash core checker.
// No dependencies.
`ifndef SHA512_256_HASH_CORE_DEFINES_SVH
`define SHA512_256_HASH_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SHC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shc_pkg.sv =====
// Package for the SHA-512/256 core: constants, round constants, a rotate function
// and the controller to datapath command and status types. No dependencies.
`timescale 1ns / 1ps
package shc_pkg;

    localparam int WordW   = 64;
    localparam int Rounds  = 80;
    localparam int WinDepth = 16;

    localparam logic [WordW-1:0] IV [8] = '{
        64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2,
        64'h2393B86B6F53B151, 64'h963877195940EABD,
        64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
        64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    localparam logic [WordW-1:0] KTab [Rounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    // Source of the word pushed into the schedule window.
    localparam logic [2:0] SRC_DATA   = 3'd0;
    localparam logic [2:0] SRC_LAST   = 3'd1;
    localparam logic [2:0] SRC_PAD80  = 3'd2;
    localparam logic [2:0] SRC_ZERO   = 3'd3;
    localparam logic [2:0] SRC_LEN_HI = 3'd4;
    localparam logic [2:0] SRC_LEN_LO = 3'd5;

    typedef struct packed {
        logic       push;       // write one word into the window
        logic [2:0] src;        // which word to write
        logic       add_bytes;  // add the transaction's byte count
        logic       start;      // load working vars from chaining value
        logic       round;      // perform one round
        logic       fold;       // add working vars into chaining value
        logic       reinit;     // restore IV, clear count and position
    } t_cmd;

    typedef struct packed {
        logic [3:0] word_pos;
        logic       last_round;
    } t_stat;

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

// ===== rtl/sha512_256_hash_core.sv =====
// SHA-512/256 hash core, top level. Depends on shc_pkg, shc_ctrl, shc_datapath.
// Flow: a word that fills a block holds the input off for the start, the 80 rounds
// and the fold. A final word adds padding pushes, one or two compressions,
// then four digest words.
// Throughput: one word is taken at a time while idle; each full block stalls input
// for its compression. The single round unit, one round per cycle, sets that limit.
// Reset: synchronous, active low; restores the IV and clears count and position.
`timescale 1ns / 1ps
module sha512_256_hash_core
    import shc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [WordW-1:0]  i_data_word,
    input  logic [3:0]        i_valid_bytes,
    input  logic              i_end_of_message,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WordW-1:0]  o_digest_word,
    output logic [1:0]        o_word_index,
    output logic              o_last_word
);
    // The controller sequences each transaction: a word is written into the
    // schedule window, and every sixteenth word starts a compression of 80
    // rounds. The last word of a message also triggers the padding words and
    // the length field, after which the four digest words are presented one
    // per transaction straight from the chaining registers.
    t_cmd       cmd;
    t_stat      stat;
    logic [1:0] dig_sel;

    shc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_end_of_message (i_end_of_message),
        .i_valid_bytes    (i_valid_bytes),
        .i_stat           (stat),
        .o_cmd            (cmd),
        .o_dig_sel        (dig_sel),
        .o_valid          (o_valid),
        .i_stall          (i_stall)
    );

    shc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_data_word      (i_data_word),
        .i_valid_bytes    (i_valid_bytes),
        .i_end_of_message (i_end_of_message),
        .i_dig_sel        (dig_sel),
        .o_dig_word       (o_digest_word),
        .o_stat           (stat)
    );

    // The digest registers hold still while a result waits to be taken.
    assign o_word_index = dig_sel;
    assign o_last_word  = (dig_sel == 2'd3);
endmodule

// ===== rtl/shc_datapath.sv =====
// Datapath of the SHA-512/256 core: schedule window, working variables, chaining
// value, byte counter and round logic. Depends on shc_pkg.
`timescale 1ns / 1ps
module shc_datapath
    import shc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [WordW-1:0]  i_data_word,
    input  logic [3:0]        i_valid_bytes,
    input  logic              i_end_of_message,
    input  logic [1:0]        i_dig_sel,
    output logic [WordW-1:0]  o_dig_word,
    output t_stat             o_stat
);
    logic [WordW-1:0] r_win [WinDepth];
    logic [WordW-1:0] r_v [8];
    logic [WordW-1:0] r_cv [8];
    logic [WordW-1:0] r_bytes;
    logic [3:0]       r_pos;
    logic [6:0]       r_rnd;

    logic [3:0]       eff_bytes;
    logic [WordW-1:0] mask, last_word, push_word;
    logic [3:0]       t0, t2, t7, t15;
    logic [WordW-1:0] a2, a15, g0, g1, w_new, w, s0, s1, ch, maj, t1, t2s;

    always_comb begin
        if (!i_end_of_message || i_valid_bytes > 4'd8) begin
            eff_bytes = 4'd8;
        end else begin
            eff_bytes = i_valid_bytes;
        end
        if (eff_bytes == 4'd0) begin
            mask = '0;
        end else begin
            mask = ~(WordW'(0)) << (7'd64 - {eff_bytes[3:0], 3'b000});
        end
        // eff_bytes is 0..7 on this path, so the marker shift stays in range.
        last_word = (i_data_word & mask)
                  | (WordW'(8'h80) << (7'd56 - {eff_bytes[3:0], 3'b000}));
        case (i_cmd.src)
            SRC_DATA:   push_word = i_data_word;
            SRC_LAST:   push_word = last_word;
            SRC_PAD80:  push_word = 64'h8000000000000000;
            SRC_LEN_HI: push_word = {61'd0, r_bytes[63:61]};
            SRC_LEN_LO: push_word = {r_bytes[60:0], 3'b000};
            default:    push_word = '0;
        endcase
    end

    always_comb begin
        t0  = r_rnd[3:0];
        t2  = t0 - 4'd2;
        t7  = t0 - 4'd7;
        t15 = t0 - 4'd15;
        a2  = r_win[t2];
        a15 = r_win[t15];
        g1  = rotr(a2, 19) ^ rotr(a2, 61) ^ (a2 >> 6);
        g0  = rotr(a15, 1) ^ rotr(a15, 8) ^ (a15 >> 7);
        w_new = g1 + r_win[t7] + g0 + r_win[t0];
        w   = (r_rnd >= 7'd16) ? w_new : r_win[t0];
        s1  = rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + s1 + ch + KTab[r_rnd] + w;
        s0  = rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2s = s0 + maj;
    end

    // Window: pushes while filling, schedule update during rounds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_win[r_pos] <= push_word;
        end else if (i_cmd.round) begin
            r_win[t0] <= w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_v <= r_cv;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_cv    <= IV;
            r_bytes <= '0;
            r_pos   <= '0;
            r_rnd   <= '0;
        end else begin
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_cv[i] <= r_cv[i] + r_v[i];
                end
            end
            if (i_cmd.add_bytes) begin
                r_bytes <= r_bytes + WordW'(eff_bytes);
            end
            if (i_cmd.push) begin
                r_pos <= r_pos + 4'd1;
            end
            if (i_cmd.start) begin
                r_rnd <= '0;
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 7'd1;
            end
        end
    end

    assign o_dig_word        = r_cv[i_dig_sel];
    assign o_stat.word_pos   = r_pos;
    assign o_stat.last_round = (r_rnd == 7'(Rounds - 1));
endmodule

// ===== rtl/shc_ctrl.sv =====
// Controller of the SHA-512/256 core: input handshake, padding sequence,
// compression sequencing and digest output. Depends on shc_pkg.
`timescale 1ns / 1ps
module shc_ctrl
    import shc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_end_of_message,
    input  logic [3:0]  i_valid_bytes,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic [1:0]  o_dig_sel,
    output logic        o_valid,
    input  logic        i_stall
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_pad, n_pad;       // padding in progress
    logic       r_need80, n_need80; // 0x80 word still to push
    logic       r_len_hi, n_len_hi; // upper length word pushed, lower one follows
    logic [1:0] r_sel, n_sel;
    logic       r_out_pending, n_out_pending;
    logic       acc, full_last;

    assign acc       = i_valid && !o_stall;
    assign full_last = (i_valid_bytes >= 4'd8);

    always_comb begin
        n_state  = r_state;
        n_pad    = r_pad;
        n_need80 = r_need80;
        n_len_hi = r_len_hi;
        n_sel    = r_sel;
        o_cmd    = '0;
        o_stall  = (r_state != ST_IDLE);
        o_valid  = (r_state == ST_OUT);
        case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.add_bytes = 1'b1;
                    if (!i_end_of_message) begin
                        o_cmd.src = SRC_DATA;
                    end else begin
                        n_pad = 1'b1;
                        if (full_last) begin
                            o_cmd.src = SRC_DATA;
                            n_need80  = 1'b1;
                        end else begin
                            o_cmd.src = SRC_LAST;
                        end
                    end
                    if (i_stat.word_pos == 4'd15) begin
                        n_state = ST_START;
                    end else if (i_end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_START: begin
                o_cmd.start = 1'b1;
                n_state     = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.last_round) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = r_pad ? ST_PAD : ST_IDLE;
            end
            ST_PAD: begin
                o_cmd.push = 1'b1;
                if (r_need80) begin
                    o_cmd.src = SRC_PAD80;
                    n_need80  = 1'b0;
                end else if (i_stat.word_pos == 4'd14) begin
                    o_cmd.src = SRC_LEN_HI;
                    n_len_hi  = 1'b1;
                end else if (i_stat.word_pos == 4'd15 && r_len_hi) begin
                    o_cmd.src = SRC_LEN_LO;
                    n_pad     = 1'b0;
                    n_len_hi  = 1'b0;
                end else begin
                    // Zeros fill the slots up to the length. A marker in the second last slot
                    // leaves no room for the length, so that block closes with zeros.
                    o_cmd.src = SRC_ZERO;
                end
                if (i_stat.word_pos == 4'd15) begin
                    n_state = ST_START;
                end
                if (i_stat.word_pos == 4'd15 && r_len_hi) begin
                    n_state = ST_START;
                    n_sel   = 2'd0;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_sel = r_sel + 2'd1;
                    if (r_sel == 2'd3) begin
                        o_cmd.reinit = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // The fold after the length word leads to the digest.
        if (r_state == ST_FOLD && !r_pad && r_sel == 2'd0 && r_need80 == 1'b0
            && r_out_pending) begin
            n_state = ST_OUT;
        end
    end

    always_comb begin
        n_out_pending = r_out_pending;
        if (r_state == ST_PAD && i_stat.word_pos == 4'd15 && r_len_hi) begin
            n_out_pending = 1'b1;
        end else if (r_state == ST_FOLD) begin
            n_out_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pad         <= 1'b0;
            r_need80      <= 1'b0;
            r_len_hi      <= 1'b0;
            r_sel         <= 2'd0;
            r_out_pending <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pad         <= n_pad;
            r_need80      <= n_need80;
            r_len_hi      <= n_len_hi;
            r_sel         <= n_sel;
            r_out_pending <= n_out_pending;
        end
    end

    assign o_dig_sel = r_sel;
endmodule

// ===== rtl/shc_checker.sv =====
// Port checker for the SHA-512/256 core, bound to the top level.
// Depends on sha512_256_hash_core_defines.svh.
`timescale 1ns / 1ps
`include "sha512_256_hash_core_defines.svh"
module shc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_digest_word,
    input logic [1:0]  o_word_index,
    input logic        o_last_word
);
    `SHC_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_valid, (o_last_word == (o_word_index == 2'd3)), "last_word does not match index")
    `SHC_ASSERT_IMPL(a_no_input_while_out, i_clk, i_rst_n, o_valid, o_stall, "input accepted during digest output")
    `SHC_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last_word, (o_valid && o_word_index == $past(o_word_index) + 2'd1), "digest words not consecutive")
    `SHC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, (o_valid && $stable(o_digest_word)), "stalled digest word changed")
endmodule

bind sha512_256_hash_core shc_checker u_shc_checker (.*);
